>>> hw/rtl/bbox_track_and_zone_counter_macros.svh
// ---------------------------------------------------------------------------
// bbox_track_and_zone_counter_macros
// Assertion macros used by the tracker RTL.
// ---------------------------------------------------------------------------
`ifndef BBOX_TRACK_AND_ZONE_COUNTER_MACROS_SVH
`define BBOX_TRACK_AND_ZONE_COUNTER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define BTZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define BTZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/btz_pkg.sv
// ---------------------------------------------------------------------------
// btz_pkg
// Types and constants of the box tracker and zone counter.
// ---------------------------------------------------------------------------
`default_nettype none
package btz_pkg;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_TOP = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_TOP = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ZONE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DIST = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_AGE = 3'd5;
    localparam logic CMD_BOX = 1'b0;
    localparam logic CMD_EOF = 1'b1;
    localparam logic [4:0] AGE_MAX = 5'd31;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Track info word layout.
    typedef struct packed {
        logic       rcnt;
        logic       lcnt;
        logic [4:0] age;
        logic [15:0] id;
    } info_t;

    // Result of one item.
    typedef struct packed {
        logic [15:0] car_id;
        logic        is_new;
        logic        dropped;
        logic [15:0] left_count;
        logic [15:0] right_count;
        logic [16:0] total_count;
    } res_t;
endpackage
`default_nettype wire

>>> hw/rtl/btz_if.sv
// ---------------------------------------------------------------------------
// btz_if
// Valid/ready channel with a generic payload.
// ---------------------------------------------------------------------------
`default_nettype none
interface btz_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/btz_ram.sv
// ---------------------------------------------------------------------------
// btz_ram
// Single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module btz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/btz_match.sv
// ---------------------------------------------------------------------------
// btz_match
// Two-stage match test of a stored track against a detected box.
// ---------------------------------------------------------------------------
`default_nettype none
module btz_match #(
    parameter int CB = 12
) (
    input  wire logic          clk,
    input  wire logic [4*CB-1:0] tbox,
    input  wire logic [4*CB-1:0] nbox,
    input  wire logic [11:0]   min_dist,
    output logic               hit
);
    // Threshold width covers both the box sides and twice the 12-bit distance.
    localparam int MW = (CB > 12) ? CB : 12;
    localparam int QW = 2*MW + 6;

    logic [CB-1:0] tx, ty, tw, th, nx, ny, nw, nh;
    logic signed [CB+2:0] dx, dy;
    logic [MW:0] t2, side, thr;
    logic [CB:0] lox, hix, loy, hiy, ox, oy;
    logic [2*CB+1:0] dx2_reg, dy2_reg, ix_reg, ta_reg, na_reg;
    logic [2*MW+1:0] thr2_reg;
    logic [2*CB+3:0] dsum;
    logic [2*CB+9:0] lhs;
    logic [2*CB+2:0] uni;

    assign {th, tw, ty, tx} = tbox;
    assign {nh, nw, ny, nx} = nbox;

    // Stage one: centers, threshold and overlap products.
    always_comb
    begin
        dx = $signed({3'b0, nx} + {4'b0, nw[CB-1:1]}) - $signed({3'b0, tx} + {4'b0, tw[CB-1:1]});
        dy = $signed({3'b0, ny} + {4'b0, nh[CB-1:1]}) - $signed({3'b0, ty} + {4'b0, th[CB-1:1]});
        t2 = (MW+1)'({min_dist, 1'b0});
        side = (tw > th) ? (MW+1)'(tw) : (MW+1)'(th);
        thr = (side > t2) ? side : t2;
        lox = (tx > nx) ? {1'b0, tx} : {1'b0, nx};
        hix = (({1'b0, tx} + tw) < ({1'b0, nx} + nw)) ? ({1'b0, tx} + tw) : ({1'b0, nx} + nw);
        loy = (ty > ny) ? {1'b0, ty} : {1'b0, ny};
        hiy = (({1'b0, ty} + th) < ({1'b0, ny} + nh)) ? ({1'b0, ty} + th) : ({1'b0, ny} + nh);
        ox = (hix > lox) ? hix - lox : '0;
        oy = (hiy > loy) ? hiy - loy : '0;
    end

    always_ff @(posedge clk)
    begin
        dx2_reg <= (2*CB+2)'(dx * dx);
        dy2_reg <= (2*CB+2)'(dy * dy);
        thr2_reg <= (2*MW+2)'(thr * thr);
        ix_reg <= (2*CB+2)'(ox * oy);
        ta_reg <= (2*CB+2)'(tw * th);
        na_reg <= (2*CB+2)'(nw * nh);
    end

    // Stage two: compares.
    always_comb
    begin
        dsum = {2'b0, dx2_reg} + {2'b0, dy2_reg};
        uni = {1'b0, ta_reg} + {1'b0, na_reg} - {1'b0, ix_reg};
        lhs = (2*CB+10)'(ix_reg) * (2*CB+10)'(200);
        hit = (QW'({dsum, 2'b00}) < QW'(thr2_reg))
            || ((ix_reg != '0) && (lhs > (2*CB+10)'(uni)));
    end
endmodule
`default_nettype wire

>>> hw/rtl/bbox_track_and_zone_counter.sv
// ---------------------------------------------------------------------------
// bbox_track_and_zone_counter
// Tracks detection boxes in a RAM-held table and counts zone entries.
// ---------------------------------------------------------------------------
// Usage: items arrive on in_ch (command, box fields); each yields exactly one
// transaction on out_ch. Configuration is written through cfg_we/cfg_idx/
// cfg_data while idle. A detection scans the table one entry per step,
// each step a RAM read plus the two-stage match unit, until a match or
// the last stored track. An end of frame walks every entry once,
// writing kept ones back compacted. Each step reads the table RAM
// through its registered read port. One item is in work at a time. The
// result sits in an output register; a stalled receiver holds it, and
// the next item is accepted the cycle after it is taken. Reset empties
// the table (count zero), next id one, counts zero; no RAM clearing
// pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bbox_track_and_zone_counter_macros.svh"
module bbox_track_and_zone_counter
    import btz_pkg::*;
#(
    parameter int MAX_TRACKS = 32,
    parameter int COORD_BITS = 12
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     command,
    input  wire logic [COORD_BITS-1:0]    box_x,
    input  wire logic [COORD_BITS-1:0]    box_y,
    input  wire logic [COORD_BITS-1:0]    box_w,
    input  wire logic [COORD_BITS-1:0]    box_h,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [15:0]                   car_id,
    output logic                          is_new,
    output logic                          dropped,
    output logic [15:0]                   left_count,
    output logic [15:0]                   right_count,
    output logic [16:0]                   total_count
);
    localparam int AW = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);
    localparam int BW = 4 * COORD_BITS;
    localparam int ZW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
    localparam logic [CW-1:0] FULL = CW'(MAX_TRACKS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_M1   = 3'd2;
    localparam logic [2:0] S_M2   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_E1   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // Configuration registers.
    logic [10:0] hw_reg;
    logic [11:0] ltop_reg, rtop_reg, zh_reg, mind_reg;
    logic [4:0]  maxage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= 11'd320;
            ltop_reg <= 12'd100;
            rtop_reg <= 12'd140;
            zh_reg <= 12'd8;
            mind_reg <= 12'd30;
            maxage_reg <= 5'd15;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_HALF_WIDTH:  hw_reg <= cfg_data[10:0];
                REG_LEFT_TOP:    ltop_reg <= cfg_data;
                REG_RIGHT_TOP:   rtop_reg <= cfg_data;
                REG_ZONE_HEIGHT: zh_reg <= cfg_data;
                REG_MIN_DIST:    mind_reg <= cfg_data;
                REG_MAX_AGE:     maxage_reg <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // Control and state registers.
    logic [2:0]   st_reg, st_next;
    logic [AW-1:0] idx_reg, idx_next, kept_reg, kept_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]  nid_reg, nid_next, lt_reg, lt_next, rt_reg, rt_next;
    logic         cmd_reg;
    logic [BW-1:0] nbox_reg;
    res_t         res_reg, res_next;
    logic         ov_reg, ov_next;

    // Table memories.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [BW-1:0] wbox, rbox;
    info_t         winfo, rinfo;
    logic          hit;

    btz_ram #(.WIDTH(BW), .DEPTH(MAX_TRACKS)) u_box (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wbox), .raddr(raddr), .rdata(rbox));
    btz_ram #(.WIDTH($bits(info_t)), .DEPTH(MAX_TRACKS)) u_info (
        .clk(clk), .we(we), .waddr(waddr), .wdata(winfo), .raddr(raddr), .rdata(rinfo));
    btz_match #(.CB(COORD_BITS)) u_match (
        .clk(clk), .tbox(rbox), .nbox(nbox_reg), .min_dist(mind_reg), .hit(hit));

    // Zone tests for the entry read at end of frame.
    logic [COORD_BITS-1:0] tx, ty, tw, th;
    logic [ZW-1:0] txz, tyz, bxe, bye, lty, rty, lye, rye, hwz, rxe;
    logic lhit, rhit;
    info_t einfo;
    logic [4:0] eage;
    logic at_last;

    always_comb
    begin
        {th, tw, ty, tx} = rbox;
        txz = ZW'(tx);
        tyz = ZW'(ty);
        bxe = txz + ZW'(tw);
        bye = tyz + ZW'(th);
        lty = ZW'(ltop_reg);
        rty = ZW'(rtop_reg);
        lye = lty + ZW'(zh_reg);
        rye = rty + ZW'(zh_reg);
        hwz = ZW'(hw_reg);
        rxe = {hwz[ZW-2:0], 1'b0};
        lhit = (hw_reg != '0) && (zh_reg != '0) && (tw != '0) && (th != '0)
            && (bye > lty) && (tyz < lye) && (txz < hwz);
        rhit = (hw_reg != '0) && (zh_reg != '0) && (tw != '0) && (th != '0)
            && (bye > rty) && (tyz < rye) && (bxe > hwz) && (txz < rxe);
        einfo = rinfo;
        eage = (rinfo.age < AGE_MAX) ? rinfo.age + 5'd1 : AGE_MAX;
        einfo.age = eage;
        if (!rinfo.lcnt && lhit)
        begin
            einfo.lcnt = 1'b1;
        end
        if (!rinfo.rcnt && rhit)
        begin
            einfo.rcnt = 1'b1;
        end
        at_last = ({1'b0, idx_reg} + 1'b1) >= {1'b0, cnt_reg};
    end

    // Sequencer.
    always_comb
    begin
        st_next = st_reg;
        idx_next = idx_reg;
        kept_next = kept_reg;
        cnt_next = cnt_reg;
        nid_next = nid_reg;
        lt_next = lt_reg;
        rt_next = rt_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        we = 1'b0;
        waddr = idx_reg;
        wbox = nbox_reg;
        winfo = rinfo;
        raddr = idx_reg;
        in_ready = (st_reg == S_IDLE) && !ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            S_IDLE:
            begin
                idx_next = '0;
                kept_next = '0;
                raddr = '0;
                if (in_valid && in_ready)
                begin
                    if (cnt_reg == '0)
                    begin
                        st_next = (command == CMD_EOF) ? S_OUT : S_DONE;
                    end
                    else
                    begin
                        st_next = (command == CMD_EOF) ? S_E1 : S_M1;
                    end
                end
            end
            S_RD:
            begin
                st_next = cmd_reg ? S_E1 : S_M1;
            end
            S_M1:
            begin
                st_next = S_M2;
            end
            S_M2:
            begin
                if (hit)
                begin
                    we = 1'b1;
                    winfo = rinfo;
                    winfo.age = '0;
                    res_next.car_id = rinfo.id;
                    res_next.is_new = 1'b0;
                    res_next.dropped = 1'b0;
                    st_next = S_OUT;
                end
                else if (at_last)
                begin
                    st_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr = idx_reg + 1'b1;
                    st_next = S_RD;
                end
            end
            S_DONE:
            begin
                res_next.car_id = '0;
                res_next.is_new = 1'b0;
                res_next.dropped = 1'b0;
                if (cnt_reg >= FULL)
                begin
                    res_next.dropped = 1'b1;
                end
                else
                begin
                    we = 1'b1;
                    waddr = AW'(cnt_reg);
                    winfo = '{rcnt: 1'b0, lcnt: 1'b0, age: 5'd0, id: nid_reg};
                    res_next.car_id = nid_reg;
                    res_next.is_new = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    nid_next = (nid_reg == 16'hFFFF) ? 16'd1 : nid_reg + 16'd1;
                end
                st_next = S_OUT;
            end
            S_E1:
            begin
                if (!rinfo.lcnt && lhit && lt_reg != CNT_MAX)
                begin
                    lt_next = lt_reg + 16'd1;
                end
                if (!rinfo.rcnt && rhit && rt_reg != CNT_MAX)
                begin
                    rt_next = rt_reg + 16'd1;
                end
                if (eage <= maxage_reg)
                begin
                    we = 1'b1;
                    waddr = kept_reg;
                    wbox = rbox;
                    winfo = einfo;
                    kept_next = kept_reg + 1'b1;
                end
                if (at_last)
                begin
                    cnt_next = CW'(kept_reg) + CW'(eage <= maxage_reg);
                    res_next.car_id = '0;
                    res_next.is_new = 1'b0;
                    res_next.dropped = 1'b0;
                    st_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr = idx_reg + 1'b1;
                    st_next = S_RD;
                end
            end
            S_OUT:
            begin
                if (cmd_reg)
                begin
                    res_next.car_id = '0;
                    res_next.is_new = 1'b0;
                    res_next.dropped = 1'b0;
                end
                res_next.left_count = lt_reg;
                res_next.right_count = rt_reg;
                res_next.total_count = {1'b0, lt_reg} + {1'b0, rt_reg};
                ov_next = 1'b1;
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            idx_reg <= '0;
            kept_reg <= '0;
            cnt_reg <= '0;
            nid_reg <= 16'd1;
            lt_reg <= '0;
            rt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            idx_reg <= idx_next;
            kept_reg <= kept_next;
            cnt_reg <= cnt_next;
            nid_reg <= nid_next;
            lt_reg <= lt_next;
            rt_reg <= rt_next;
            ov_reg <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_valid && in_ready)
        begin
            cmd_reg <= command;
            nbox_reg <= {box_h, box_w, box_y, box_x};
        end
    end

    assign out_valid = ov_reg;
    assign car_id = res_reg.car_id;
    assign is_new = res_reg.is_new;
    assign dropped = res_reg.dropped;
    assign left_count = res_reg.left_count;
    assign right_count = res_reg.right_count;
    assign total_count = res_reg.total_count;

    // Checks.
    `BTZ_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= FULL)
    `BTZ_ASSERT_IMP(a_flags, clk, rst_n, out_valid, !(is_new && dropped))
    `BTZ_ASSERT_NEXT(a_no_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
    `BTZ_ASSERT_IMP(a_nid_nz, clk, rst_n, 1'b1, nid_reg != 16'd0)
endmodule
`default_nettype wire

>>> test/bbox_track_and_zone_counter_tb.sv
// ---------------------------------------------------------------------------
// bbox_track_and_zone_counter_tb
// Self-checking bench for the box tracker and zone counter. Detection and
// end-of-frame transactions go in through a valid/ready channel. A
// scoreboard keeps its own copy of the track table and works out each
// expected result, which is then compared field by field with the output.
// The run covers several register settings and idle/stall patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module bbox_track_and_zone_counter_tb
    import btz_pkg::*;
();

    localparam int NTRK = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic        cmd;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
    } det_t;

    localparam int DET_BITS = $bits(det_t);

    // Scoreboard: mirrors the track table and queues expected results
    class track_scoreboard;
        logic [11:0] tx[NTRK], ty[NTRK], tw[NTRK], th[NTRK];
        logic [15:0] tid[NTRK];
        logic [4:0]  tage[NTRK];
        logic        tleft[NTRK], tright[NTRK];
        int          cnt;
        logic [15:0] next_id, left_tot, right_tot;
        logic [10:0] half_w;
        logic [11:0] left_top, right_top, zone_h, min_dist;
        logic [4:0]  max_age;
        res_t        expected_q[$];
        int          errors;

        function void init();
            cnt = 0; next_id = 1; left_tot = 0; right_tot = 0;
            half_w = 320; left_top = 100; right_top = 140; zone_h = 8;
            min_dist = 30; max_age = 15; errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [11:0] v);
            case (idx)
                REG_HALF_WIDTH:  half_w = v[10:0];
                REG_LEFT_TOP:    left_top = v;
                REG_RIGHT_TOP:   right_top = v;
                REG_ZONE_HEIGHT: zone_h = v;
                REG_MIN_DIST:    min_dist = v;
                REG_MAX_AGE:     max_age = v[4:0];
                default: ;
            endcase
        endfunction

        function longint span(longint a0, longint al, longint b0, longint bl);
            longint lo, hi;
            lo = (a0 > b0) ? a0 : b0;
            hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
            return (hi > lo) ? hi - lo : 0;
        endfunction

        function bit in_zone(int k, longint zx, longint zy, longint zw, longint zh);
            return span(tx[k], tw[k], zx, zw) > 0 && span(ty[k], th[k], zy, zh) > 0;
        endfunction

        function bit is_match(int k, det_t d);
            longint dx, dy, t, side, inter, uni;
            dx = (longint'(d.x) + d.w / 2) - (longint'(tx[k]) + tw[k] / 2);
            dy = (longint'(d.y) + d.h / 2) - (longint'(ty[k]) + th[k] / 2);
            t = 2 * longint'(min_dist);
            side = (tw[k] > th[k]) ? tw[k] : th[k];
            if (side > t)
                t = side;
            if (4 * (dx * dx + dy * dy) < t * t)
                return 1;
            inter = span(tx[k], tw[k], d.x, d.w) * span(ty[k], th[k], d.y, d.h);
            uni = longint'(tw[k]) * th[k] + longint'(d.w) * d.h - inter;
            return inter > 0 && 200 * inter > uni;
        endfunction

        // Predict the result of one accepted transaction
        function void note_item(det_t d);
            res_t r;
            int   kept;
            bit   found;
            r = '0;
            if (d.cmd == CMD_EOF) begin
                kept = 0;
                for (int i = 0; i < cnt; i++) begin
                    if (!tleft[i] && in_zone(i, 0, left_top, half_w, zone_h)) begin
                        if (left_tot != CNT_MAX) left_tot++;
                        tleft[i] = 1;
                    end
                    if (!tright[i] && in_zone(i, half_w, right_top, half_w, zone_h)) begin
                        if (right_tot != CNT_MAX) right_tot++;
                        tright[i] = 1;
                    end
                    if (tage[i] != AGE_MAX) tage[i]++;
                    if (tage[i] <= max_age) begin
                        tx[kept] = tx[i]; ty[kept] = ty[i];
                        tw[kept] = tw[i]; th[kept] = th[i];
                        tid[kept] = tid[i]; tage[kept] = tage[i];
                        tleft[kept] = tleft[i]; tright[kept] = tright[i];
                        kept++;
                    end
                end
                cnt = kept;
            end else begin
                found = 0;
                for (int i = 0; i < cnt && !found; i++) begin
                    if (is_match(i, d)) begin
                        tx[i] = d.x; ty[i] = d.y; tw[i] = d.w; th[i] = d.h;
                        tage[i] = 0;
                        r.car_id = tid[i];
                        found = 1;
                    end
                end
                if (!found) begin
                    if (cnt >= NTRK) begin
                        r.dropped = 1;
                    end else begin
                        tx[cnt] = d.x; ty[cnt] = d.y; tw[cnt] = d.w; th[cnt] = d.h;
                        tid[cnt] = next_id; tage[cnt] = 0;
                        tleft[cnt] = 0; tright[cnt] = 0;
                        cnt++;
                        r.car_id = next_id;
                        r.is_new = 1;
                        next_id = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
                    end
                end
            end
            r.left_count = left_tot;
            r.right_count = right_tot;
            r.total_count = {1'b0, left_tot} + {1'b0, right_tot};
            expected_q = {expected_q, r};
        endfunction

        // Compare one output transaction with the oldest prediction
        function void check_result(res_t got);
            res_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.car_id !== e.car_id)
                $display("%0t: car_id expected %0d actual %0d", $time, e.car_id, got.car_id);
            if (got.is_new !== e.is_new)
                $display("%0t: is_new expected %0d actual %0d", $time, e.is_new, got.is_new);
            if (got.dropped !== e.dropped)
                $display("%0t: dropped expected %0d actual %0d", $time, e.dropped, got.dropped);
            if (got.left_count !== e.left_count)
                $display("%0t: left_count expected %0d actual %0d", $time,
                         e.left_count, got.left_count);
            if (got.right_count !== e.right_count)
                $display("%0t: right_count expected %0d actual %0d", $time,
                         e.right_count, got.right_count);
            if (got.total_count !== e.total_count)
                $display("%0t: total_count expected %0d actual %0d", $time,
                         e.total_count, got.total_count);
            if (got !== e)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic [15:0] car_id, left_count, right_count;
    logic is_new, dropped;
    logic [16:0] total_count;

    btz_if #(.T(det_t)) in_ch ();
    btz_if #(.T(res_t)) out_ch ();

    track_scoreboard sb;
    int idle_pct;
    int stall_pct;
    bit hold_req;
    int quiet_cycles;

    assign out_ch.data = '{car_id, is_new, dropped, left_count, right_count, total_count};

    bbox_track_and_zone_counter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .command     (in_ch.data.cmd),
        .box_x       (in_ch.data.x),
        .box_y       (in_ch.data.y),
        .box_w       (in_ch.data.w),
        .box_h       (in_ch.data.h),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .car_id      (car_id),
        .is_new      (is_new),
        .dropped     (dropped),
        .left_count  (left_count),
        .right_count (right_count),
        .total_count (total_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Output monitor
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(det_t d);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= d;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_item(d);
        @(negedge clk);
    endtask

    task automatic send_box(int x, int y, int w, int h);
        send_item('{CMD_BOX, x[11:0], y[11:0], w[11:0], h[11:0]});
    endtask

    task automatic send_eof();
        det_t d;
        d = DET_BITS'($urandom());
        d.cmd = CMD_EOF;
        send_item(d);
    endtask

    // Register write once the block has drained
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [11:0] v);
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(int hw, int lt, int rt, int zh, int md, int ma);
        write_reg(REG_HALF_WIDTH, hw[11:0]);
        write_reg(REG_LEFT_TOP, lt[11:0]);
        write_reg(REG_RIGHT_TOP, rt[11:0]);
        write_reg(REG_ZONE_HEIGHT, zh[11:0]);
        write_reg(REG_MIN_DIST, md[11:0]);
        write_reg(REG_MAX_AGE, ma[11:0]);
    endtask

    // Random transaction: mostly follow-ups of live tracks and zone boxes
    task automatic send_random();
        int   r, k;
        det_t d;
        r = $urandom_range(99);
        d = DET_BITS'({$urandom(), $urandom()});
        d.cmd = CMD_BOX;
        if (r < 12)
            d.cmd = CMD_EOF;
        else if (r < 62 && sb.cnt > 0)
        begin
            k = $urandom_range(sb.cnt - 1);
            d.x = sb.tx[k] + 12'($urandom_range(40)) - 12'd20;
            d.y = sb.ty[k] + 12'($urandom_range(40)) - 12'd20;
            d.w = sb.tw[k] + 12'($urandom_range(10)) - 12'd5;
            d.h = sb.th[k] + 12'($urandom_range(10)) - 12'd5;
        end
        else if (r < 88)
        begin
            d.x = 12'($urandom_range(2 * sb.half_w + 60));
            d.y = ($urandom_range(1) ? sb.left_top : sb.right_top)
                  + 12'($urandom_range(60)) - 12'd40;
            d.w = 12'($urandom_range(50));
            d.h = 12'($urandom_range(50));
        end
        send_item(d);
    endtask

    // Many far-apart small boxes to fill the table and force drops
    task automatic fill_table(int n);
        for (int k = 0; k < n; k++)
            send_box((k % 8) * 500 + $urandom_range(50), (k / 8) * 500 + $urandom_range(50),
                     $urandom_range(1, 8), $urandom_range(1, 8));
    endtask

    initial
    begin
        sb = new();
        sb.init();
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, distance and overlap matches, zones, frames
        send_box(0, 0, 0, 0);
        send_box(4095, 4095, 4095, 4095);
        send_box(5, 5, 10, 10);
        send_box(100, 98, 20, 20);
        send_box(400, 138, 30, 30);
        send_box(1000, 1000, 400, 400);
        send_box(1150, 1150, 400, 400);
        send_box(310, 100, 20, 4);
        send_box(2000, 104, 0, 50);
        send_eof();
        send_eof();
        send_box(101, 99, 20, 20);
        send_box(3000, 3000, 7, 0);
        send_eof();

        // Phase 1: default registers, no idling, one long receiver hold-off
        hold_req = 1;
        for (int i = 0; i < 150; i++)
            send_random();

        // Phase 2: wide zones, largest match distance, tracks expire every frame
        write_all(2047, 0, 0, 4095, 4095, 0);
        idle_pct = 87;
        stall_pct = 0;
        for (int i = 0; i < 150; i++)
            send_random();

        // Phase 3: thin zones, distance off, tracks never expire; table fills
        write_all(1, 4095, 4095, 1, 0, 0);
        send_eof();
        send_eof();
        write_reg(REG_MAX_AGE, 12'd31);
        idle_pct = 0;
        stall_pct = 87;
        fill_table(40);
        for (int i = 0; i < 110; i++)
            send_random();

        // Phase 4: random registers, both sides idling
        idle_pct = 23;
        stall_pct = 23;
        for (int p = 0; p < 3; p++)
        begin
            write_all($urandom_range(1, 2047), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(1, 400),
                      $urandom_range(0, 100), $urandom_range(0, 30));
            for (int i = 0; i < 50; i++)
                send_random();
        end

        // Drain and report
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
